// File: hdl/hcb_pkg.sv
package hcb_pkg;

    localparam int SYM_W            = 8;
    localparam int WGT_W            = 24;
    localparam int LEN_W            = 6;
    localparam int CODE_W           = 63;
    // Tree weights: up to 64 leaves of 24 bits each
    localparam int NWGT_W           = 30;
    localparam int SYMBOLS_DEF      = 64;
    localparam int MAX_CODE_LEN_DEF = 63;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [WGT_W-1:0] weight;
        logic             last;
    } in_item_t;

    typedef struct packed {
        logic [SYM_W-1:0]  code_symbol;
        logic [LEN_W-1:0]  code_length;
        logic [CODE_W-1:0] code_bits;
        logic              overflow;
        logic              final_code;
    } out_item_t;

    // Datapath micro-operations issued by the controller
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_HINIT,
        CMD_HRD,
        CMD_HNEXT,
        CMD_CAPI,
        CMD_SDL,
        CMD_SDR,
        CMD_SDC,
        CMD_TRD0,
        CMD_TOPA,
        CMD_TOPB,
        CMD_MERGE,
        CMD_PRD,
        CMD_PCMP,
        CMD_PFIN,
        CMD_ROOT,
        CMD_PUSH,
        CMD_LEFT,
        CMD_LEAFRD,
        CMD_CAPOUT,
        CMD_POP,
        CMD_FIN,
        CMD_RSTK,
        CMD_RCH,
        CMD_RCAP,
        CMD_CLEAR
    } cmd_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic n_ge2;
        logic h_zero;
        logic hc_gt1;
        logic sd_move;
        logic i_nz;
        logic put_move;
        logic internal;
        logic can_push;
        logic pop_more;
        logic out_taken;
        logic out_final;
    } status_t;

endpackage

// File: hdl/hcb_dp.sv
module hcb_dp #(
    parameter int SYMBOLS      = hcb_pkg::SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hcb_pkg::MAX_CODE_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hcb_pkg::cmd_t      cmd,
    input  hcb_pkg::in_item_t  in_data,
    input  logic               out_ready,
    output hcb_pkg::status_t   status,
    output logic               out_valid,
    output hcb_pkg::out_item_t out_data
);
    import hcb_pkg::*;

    localparam int NODES = 2 * SYMBOLS - 1;
    localparam int IW    = $clog2(SYMBOLS);
    localparam int NW    = $clog2(NODES);
    localparam int CW    = $clog2(SYMBOLS + 1);
    localparam int LW    = $clog2(SYMBOLS);
    localparam int XW    = IW + 2;

    typedef struct packed {
        logic [NW-1:0]     node;
        logic [NWGT_W-1:0] w;
    } hent_t;

    // Storage
    hent_t            heap_mem  [SYMBOLS];
    logic [SYM_W-1:0] leaf_mem  [SYMBOLS];
    logic [NW-1:0]    left_mem  [NODES];
    logic [NW-1:0]    right_mem [NODES];
    logic [NW-1:0]    stack_mem [SYMBOLS];

    hent_t            hrdata_reg;
    logic [SYM_W-1:0] leaf_rdata_reg;
    logic [NW-1:0]    left_rdata_reg;
    logic [NW-1:0]    right_rdata_reg;
    logic [NW-1:0]    stack_rdata_reg;

    // Control and working registers
    logic [CW-1:0]     loaded_reg;
    logic [CW-1:0]     hc_reg;
    logic [NW-1:0]     next_reg;
    logic [IW-1:0]     h_reg;
    logic [IW-1:0]     i_reg;
    hent_t             ei_reg;
    hent_t             el_reg;
    hent_t             a_reg;
    hent_t             b_reg;
    logic [NW-1:0]     pn_reg;
    logic [NWGT_W-1:0] pw_reg;
    logic [NW-1:0]     node_reg;
    logic [LW-1:0]     len_reg;
    logic [CODE_W-1:0] path_reg;
    logic [CW-1:0]     cnt_reg;
    logic              dropped_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    // Heap index arithmetic
    logic [XW-1:0] l_idx;
    logic [XW-1:0] r_idx;
    logic          l_in;
    logic          r_in;
    logic [CW-1:0] hc_m1;
    logic [IW-1:0] parent;
    logic [CW-1:0] h_start;
    logic          move;
    logic [IW-1:0] s_idx;
    hent_t         s_ent;
    logic          room;

    assign l_idx   = XW'({i_reg, 1'b0}) + XW'(1);
    assign r_idx   = XW'({i_reg, 1'b0}) + XW'(2);
    assign l_in    = l_idx < XW'(hc_reg);
    assign r_in    = r_idx < XW'(hc_reg);
    assign hc_m1   = hc_reg - CW'(1);
    assign parent  = (i_reg - IW'(1)) >> 1;
    assign h_start = (loaded_reg - CW'(2)) >> 1;
    assign room    = loaded_reg < CW'(SYMBOLS);

    // Sift-down child choice: strict less, left wins ties
    always_comb
    begin
        logic [NWGT_W-1:0] ws;
        ws    = ei_reg.w;
        move  = 1'b0;
        s_idx = i_reg;
        s_ent = ei_reg;
        if (l_in && el_reg.w < ws)
        begin
            ws    = el_reg.w;
            move  = 1'b1;
            s_idx = l_idx[IW-1:0];
            s_ent = el_reg;
        end
        if (r_in && hrdata_reg.w < ws)
        begin
            move  = 1'b1;
            s_idx = r_idx[IW-1:0];
            s_ent = hrdata_reg;
        end
    end

    // Heap read address
    logic [IW-1:0] haddr;
    always_comb
    begin
        case (cmd)
            CMD_HRD:             haddr = h_reg;
            CMD_SDL:             haddr = l_idx[IW-1:0];
            CMD_SDR:             haddr = r_idx[IW-1:0];
            CMD_TOPA, CMD_TOPB:  haddr = hc_m1[IW-1:0];
            CMD_PRD:             haddr = parent;
            default:             haddr = '0;
        endcase
    end

    // Heap write port
    logic          hwe;
    logic [IW-1:0] hwaddr;
    hent_t         hwdata;
    always_comb
    begin
        hwe    = 1'b0;
        hwaddr = i_reg;
        hwdata = ei_reg;
        case (cmd)
            CMD_LOAD:
            begin
                hwe         = room;
                hwaddr      = loaded_reg[IW-1:0];
                hwdata.node = NW'(loaded_reg);
                hwdata.w    = NWGT_W'(in_data.weight);
            end
            CMD_SDC:
            begin
                hwe    = 1'b1;
                hwdata = move ? s_ent : ei_reg;
            end
            CMD_PCMP:
            begin
                hwe    = 1'b1;
                hwdata = (pw_reg < hrdata_reg.w) ? hrdata_reg : hent_t'({pn_reg, pw_reg});
            end
            CMD_PFIN:
            begin
                hwe    = 1'b1;
                hwdata = hent_t'({pn_reg, pw_reg});
            end
            default:
            begin
                hwe = 1'b0;
            end
        endcase
    end

    logic [NW-1:0] caddr;
    assign caddr = (cmd == CMD_RCH) ? stack_rdata_reg : node_reg;

    // Memories
    always_ff @(posedge clk)
    begin
        if (hwe)
            heap_mem[hwaddr] <= hwdata;
        hrdata_reg <= heap_mem[haddr];
        if (cmd == CMD_LOAD && room)
            leaf_mem[loaded_reg[IW-1:0]] <= in_data.symbol;
        leaf_rdata_reg <= leaf_mem[node_reg[IW-1:0]];
        if (cmd == CMD_MERGE)
        begin
            left_mem[next_reg]  <= a_reg.node;
            right_mem[next_reg] <= b_reg.node;
        end
        left_rdata_reg  <= left_mem[caddr];
        right_rdata_reg <= right_mem[caddr];
        if (cmd == CMD_PUSH)
            stack_mem[len_reg] <= node_reg;
        stack_rdata_reg <= stack_mem[len_reg - LW'(1)];
    end

    // Result formatting for the current leaf
    logic [6:0]        len_x;
    logic [LEN_W-1:0]  olen;
    logic [CODE_W-1:0] ocode;
    assign len_x = 7'(len_reg);
    always_comb
    begin
        if (len_x > 7'(MAX_CODE_LEN))
        begin
            olen  = LEN_W'(MAX_CODE_LEN);
            ocode = path_reg >> (len_x - 7'(MAX_CODE_LEN));
        end
        else
        begin
            olen  = LEN_W'(len_reg);
            ocode = path_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            hc_reg        <= '0;
            path_reg      <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (cmd)
                CMD_LOAD:
                begin
                    if (room)
                        loaded_reg <= loaded_reg + CW'(1);
                    else
                        dropped_reg <= 1'b1;
                end
                CMD_HINIT:         hc_reg <= loaded_reg;
                CMD_TOPA, CMD_TOPB: hc_reg <= hc_m1;
                CMD_MERGE:         hc_reg <= hc_reg + CW'(1);
                CMD_ROOT:          path_reg <= '0;
                CMD_PUSH:          path_reg <= {path_reg[CODE_W-2:0], 1'b0};
                CMD_POP:           path_reg <= path_reg >> 1;
                CMD_RSTK:          path_reg <= path_reg | CODE_W'(1);
                CMD_FIN:           out_valid_reg <= 1'b1;
                CMD_CLEAR:
                begin
                    loaded_reg  <= '0;
                    hc_reg      <= '0;
                    path_reg    <= '0;
                    dropped_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_HINIT:
            begin
                next_reg <= NW'(loaded_reg);
                h_reg    <= h_start[IW-1:0];
            end
            CMD_HRD:   i_reg <= h_reg;
            CMD_HNEXT: h_reg <= h_reg - IW'(1);
            CMD_CAPI:  ei_reg <= hrdata_reg;
            CMD_SDR:   el_reg <= hrdata_reg;
            CMD_SDC:
            begin
                if (move)
                    i_reg <= s_idx;
            end
            CMD_TOPA:
            begin
                a_reg <= hrdata_reg;
                i_reg <= '0;
            end
            CMD_TOPB:
            begin
                b_reg <= hrdata_reg;
                i_reg <= '0;
            end
            CMD_MERGE:
            begin
                pn_reg   <= next_reg;
                pw_reg   <= a_reg.w + b_reg.w;
                next_reg <= next_reg + NW'(1);
                i_reg    <= hc_reg[IW-1:0];
            end
            CMD_PCMP:
            begin
                if (pw_reg < hrdata_reg.w)
                    i_reg <= parent;
            end
            CMD_ROOT:
            begin
                node_reg <= hrdata_reg.node;
                len_reg  <= '0;
                cnt_reg  <= '0;
            end
            CMD_PUSH:  len_reg  <= len_reg + LW'(1);
            CMD_LEFT:  node_reg <= left_rdata_reg;
            CMD_RCAP:  node_reg <= right_rdata_reg;
            CMD_POP:   len_reg  <= len_reg - LW'(1);
            CMD_CAPOUT:
            begin
                out_reg.code_symbol <= leaf_rdata_reg;
                out_reg.code_length <= olen;
                out_reg.code_bits   <= ocode;
                out_reg.overflow    <= dropped_reg;
                out_reg.final_code  <= 1'b0;
            end
            CMD_FIN:
            begin
                out_reg.final_code <= (len_reg == '0) ||
                                      ((7'(cnt_reg) + 7'(1)) >= 7'(SYMBOLS));
                cnt_reg <= cnt_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Status
    assign status.n_ge2     = loaded_reg >= CW'(2);
    assign status.h_zero    = h_reg == '0;
    assign status.hc_gt1    = hc_reg > CW'(1);
    assign status.sd_move   = move;
    assign status.i_nz      = i_reg != '0;
    assign status.put_move  = pw_reg < hrdata_reg.w;
    assign status.internal  = node_reg >= NW'(loaded_reg);
    assign status.can_push  = len_reg < LW'(SYMBOLS - 1);
    assign status.pop_more  = (len_reg != '0) && path_reg[0];
    assign status.out_taken = out_valid_reg && out_ready;
    assign status.out_final = out_reg.final_code;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: hdl/hcb_ctrl.sv
module hcb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    input  hcb_pkg::status_t status,
    output logic             in_ready,
    output hcb_pkg::cmd_t    cmd
);
    import hcb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_HINIT, S_HRD, S_HNEXT, S_CAP, S_SDL, S_SDR, S_SDC,
        S_MCHK, S_TRD0, S_TOP, S_MERGE, S_PRD, S_PCMP, S_RRD, S_ROOT,
        S_WALK, S_LEFT, S_LEAF, S_POP, S_EMIT, S_RS, S_RC, S_DONE
    } state_t;

    // Where a finished sift-down returns to
    typedef enum logic [1:0] {
        RET_HEAP, RET_A, RET_B
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = CMD_NOP;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = CMD_LOAD;
                    if (in_last)
                        state_next = S_HINIT;
                end
            end
            S_HINIT:
            begin
                cmd        = CMD_HINIT;
                ret_next   = RET_HEAP;
                state_next = status.n_ge2 ? S_HRD : S_MCHK;
            end
            S_HRD:
            begin
                cmd        = CMD_HRD;
                state_next = S_CAP;
            end
            S_HNEXT:
            begin
                cmd        = CMD_HNEXT;
                state_next = S_HRD;
            end
            S_CAP:
            begin
                cmd        = CMD_CAPI;
                state_next = S_SDL;
            end
            S_SDL:
            begin
                cmd        = CMD_SDL;
                state_next = S_SDR;
            end
            S_SDR:
            begin
                cmd        = CMD_SDR;
                state_next = S_SDC;
            end
            S_SDC:
            begin
                cmd = CMD_SDC;
                if (status.sd_move)
                    state_next = S_SDL;
                else
                begin
                    unique case (ret_reg)
                        RET_HEAP: state_next = status.h_zero ? S_MCHK : S_HNEXT;
                        RET_A:
                        begin
                            ret_next   = RET_B;
                            state_next = S_TRD0;
                        end
                        RET_B:    state_next = S_MERGE;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_MCHK:
            begin
                if (status.hc_gt1)
                begin
                    ret_next   = RET_A;
                    state_next = S_TRD0;
                end
                else
                    state_next = S_RRD;
            end
            S_TRD0:
            begin
                cmd        = CMD_TRD0;
                state_next = S_TOP;
            end
            S_TOP:
            begin
                cmd        = (ret_reg == RET_B) ? CMD_TOPB : CMD_TOPA;
                state_next = S_CAP;
            end
            S_MERGE:
            begin
                cmd        = CMD_MERGE;
                state_next = S_PRD;
            end
            S_PRD:
            begin
                if (status.i_nz)
                begin
                    cmd        = CMD_PRD;
                    state_next = S_PCMP;
                end
                else
                begin
                    cmd        = CMD_PFIN;
                    state_next = S_MCHK;
                end
            end
            S_PCMP:
            begin
                cmd        = CMD_PCMP;
                state_next = status.put_move ? S_PRD : S_MCHK;
            end
            S_RRD:
            begin
                cmd        = CMD_TRD0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd        = CMD_ROOT;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (status.internal)
                begin
                    if (status.can_push)
                    begin
                        cmd        = CMD_PUSH;
                        state_next = S_LEFT;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_LEAFRD;
                    state_next = S_LEAF;
                end
            end
            S_LEFT:
            begin
                cmd        = CMD_LEFT;
                state_next = S_WALK;
            end
            S_LEAF:
            begin
                cmd        = CMD_CAPOUT;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (status.pop_more)
                    cmd = CMD_POP;
                else
                begin
                    cmd        = CMD_FIN;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_taken)
                begin
                    if (status.out_final)
                        state_next = S_DONE;
                    else
                    begin
                        cmd        = CMD_RSTK;
                        state_next = S_RS;
                    end
                end
            end
            S_RS:
            begin
                cmd        = CMD_RCH;
                state_next = S_RC;
            end
            S_RC:
            begin
                cmd        = CMD_RCAP;
                state_next = S_WALK;
            end
            S_DONE:
            begin
                cmd        = CMD_CLEAR;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_HEAP;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

// File: hdl/huffman_code_builder_unit.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_data  (symbol, weight, last)
// out     | output    | out_valid/out_ready  | out_data (symbol, length, bits, flags)
//
// Loading takes one cycle per pair. The pair with last set starts the build:
// heapify and each extraction sift down through SDL, SDR and SDC per level and
// sift up through PRD and PCMP per level, all through the heap's one read port.
// Each code then descends through WALK and LEFT per level, is captured in LEAF,
// pops levels in POP, waits in EMIT for out_ready, and resumes through RS and RC.
// No input is taken meanwhile.
// Reset clears counts, flags and the output valid; memories need no clearing.
module huffman_code_builder_unit #(
    parameter int SYMBOLS      = hcb_pkg::SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hcb_pkg::MAX_CODE_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hcb_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hcb_pkg::out_item_t out_data
);
    import hcb_pkg::*;

    cmd_t    cmd;
    status_t status;

    hcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.last),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    hcb_dp #(
        .SYMBOLS      (SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // No loading while a code is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while a code is pending");

    // A final pair ends loading
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last |=> !in_ready)
        else $error("input still ready after final pair");

    // The run's last code returns the unit to loading
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.final_code |-> ##2 in_ready)
        else $error("unit not ready after final code");

    // One code transfer is followed by a gap while the walk resumes or the run ends
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("code offered right after a transfer");

endmodule

// File: tb/hcb_checker.sv
module hcb_checker
    import hcb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        codes_seen,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSYM = SYMBOLS_DEF;
    localparam int NODES = 2 * NSYM - 1;

    // predictor state
    logic [SYM_W-1:0]  leaf_sym [NSYM];
    logic [NWGT_W-1:0] node_wgt [NODES];
    int                lchild [NODES];
    int                rchild [NODES];
    int                heap [NSYM];
    int                heap_n;
    int                loaded;
    logic              dropped;
    out_item_t         code_queue [$];

    function automatic logic [NWGT_W-1:0] slot_wgt(int s);
        return node_wgt[heap[s]];
    endfunction

    function automatic void sink(int i);
        int s, l, r, t;
        forever
        begin
            s = i;
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (l < heap_n && slot_wgt(l) < slot_wgt(s)) s = l;
            if (r < heap_n && slot_wgt(r) < slot_wgt(s)) s = r;
            if (s == i) return;
            t = heap[s];
            heap[s] = heap[i];
            heap[i] = t;
            i = s;
        end
    endfunction

    function automatic int pop_min();
        int top;
        top = heap[0];
        heap[0] = heap[heap_n - 1];
        heap_n--;
        sink(0);
        return top;
    endfunction

    function automatic void raise(int node);
        int i;
        heap_n++;
        i = heap_n - 1;
        while (i != 0 && node_wgt[node] < slot_wgt((i - 1) / 2))
        begin
            heap[i] = heap[(i - 1) / 2];
            i = (i - 1) / 2;
        end
        heap[i] = node;
    endfunction

    // Load one pair; on last build the tree and queue its codes
    function automatic void take_pair(in_item_t p);
        int n, nxt, a, b, node, len, cnt;
        int stk [NSYM];
        logic [CODE_W-1:0] path;
        out_item_t o;
        if (loaded < NSYM)
        begin
            leaf_sym[loaded] = p.symbol;
            node_wgt[loaded] = NWGT_W'(p.weight);
            loaded++;
        end
        else
            dropped = 1'b1;
        if (!p.last) return;
        n = loaded;
        for (int i = 0; i < n; i++) heap[i] = i;
        heap_n = n;
        if (n >= 2)
            for (int i = (n - 2) / 2; i >= 0; i--) sink(i);
        nxt = n;
        while (heap_n > 1)
        begin
            a = pop_min();
            b = pop_min();
            node_wgt[nxt] = node_wgt[a] + node_wgt[b];
            lchild[nxt] = a;
            rchild[nxt] = b;
            raise(nxt);
            nxt++;
        end
        node = pop_min();
        len = 0;
        path = '0;
        cnt = 0;
        forever
        begin
            if (node >= n)
            begin
                if (len < NSYM - 1)
                begin
                    stk[len] = node;
                    path = path << 1;
                    len++;
                    node = lchild[node];
                    continue;
                end
                break;
            end
            o.code_symbol = leaf_sym[node];
            o.code_length = LEN_W'(len);
            o.code_bits   = path;
            o.overflow    = dropped;
            o.final_code  = 1'b0;
            code_queue.push_back(o);
            cnt++;
            while (len > 0 && path[0])
            begin
                len--;
                path = path >> 1;
            end
            if (len == 0 || cnt >= NSYM) break;
            path[0] = 1'b1;
            node = rchild[stk[len - 1]];
        end
        code_queue[$].final_code = 1'b1;
        loaded = 0;
        heap_n = 0;
        dropped = 1'b0;
    endfunction

    task automatic report(string what, logic [CODE_W-1:0] got, logic [CODE_W-1:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        codes_seen = 0;
        loaded = 0;
        heap_n = 0;
        dropped = 1'b0;
    end

    assign pending = code_queue.size();

    always @(posedge clk)
    begin
        out_item_t w;
        if (rst_n)
        begin
            if (in_valid && in_ready) take_pair(in_data);
            if (out_valid && out_ready)
            begin
                codes_seen++;
                if (code_queue.size() == 0)
                    report("unexpected transfer", CODE_W'(out_data.code_symbol), '0);
                else
                begin
                    w = code_queue.pop_front();
                    if (out_data.code_symbol !== w.code_symbol)
                        report("symbol", CODE_W'(out_data.code_symbol),
                               CODE_W'(w.code_symbol));
                    if (out_data.code_length !== w.code_length)
                        report("length", CODE_W'(out_data.code_length),
                               CODE_W'(w.code_length));
                    if (out_data.code_bits !== w.code_bits)
                        report("bits", out_data.code_bits, w.code_bits);
                    if (out_data.overflow !== w.overflow)
                        report("overflow", CODE_W'(out_data.overflow),
                               CODE_W'(w.overflow));
                    if (out_data.final_code !== w.final_code)
                        report("final", CODE_W'(out_data.final_code),
                               CODE_W'(w.final_code));
                end
            end
        end
    end
endmodule

// File: tb/tb_huffman_code_builder_unit.sv
module tb_huffman_code_builder_unit;
    import hcb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 1500000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        fail_count;
    int        codes_seen;
    int        pending;
    int        cycles;
    int        sent;
    int        runs;
    int        burst;

    huffman_code_builder_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    hcb_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .fail_count(fail_count),
        .codes_seen(codes_seen),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver stall pattern: phases of steady ready and phases of random stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if ((cycles / 400) % 3 == 0)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("huffman_code_builder_unit verification failed");
            $finish;
        end
    end

    // One transfer; gaps between bursts of random length
    task automatic send(logic [SYM_W-1:0] s, logic [WGT_W-1:0] w, logic l);
        in_item_t p;
        if (burst == 0)
        begin
            burst = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst--;
        p.symbol = s;
        p.weight = w;
        p.last   = l;
        in_data  <= p;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sent++;
        if (l) runs++;
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
    endtask

    // Random alphabet of n pairs with weights of a chosen style
    task automatic send_run(int n, int style);
        logic [WGT_W-1:0] w;
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0: w = WGT_W'($urandom_range(0, 15));
                1: w = WGT_W'($urandom());
                2: w = WGT_W'(1) << (i % WGT_W);
                default: w = WGT_W'($urandom_range(0, 3));
            endcase
            send(SYM_W'($urandom()), w, i == n - 1);
        end
    endtask

    initial
    begin
        cycles = 0;
        sent = 0;
        runs = 0;
        burst = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lone symbol, two symbols at weight extremes, ties
        send(8'hFF, 24'hFFFFFF, 1'b1);
        send(8'h00, 24'h000000, 1'b0);
        send(8'hFF, 24'hFFFFFF, 1'b1);
        send(8'h55, 24'd5, 1'b0);
        send(8'hAA, 24'd5, 1'b0);
        send(8'h0F, 24'd5, 1'b1);
        // Deep codes: weights double from pair to pair, restarting after 24 pairs
        send_run(30, 2);
        // Overflow: 66 pairs, last pair dropped too
        send_run(66, 3);

        // Random runs, mostly small alphabets, a few of 60 to 66 pairs
        while (sent < 260)
        begin
            if ($urandom_range(0, 9) == 0)
                send_run($urandom_range(60, 66), $urandom_range(0, 3));
            else
                send_run($urandom_range(1, 12), $urandom_range(0, 3));
        end
        go_idle();

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("runs %0d, pairs %0d, codes checked %0d", runs, sent, codes_seen);
        $display("covered lone symbols, ties, deep codes and dropped pairs");
        if (fail_count == 0)
            $display("huffman_code_builder_unit verification clean");
        else
            $display("huffman_code_builder_unit verification failed");
        $finish;
    end
endmodule

// File: filelist.f
hdl/hcb_pkg.sv
hdl/hcb_dp.sv
hdl/hcb_ctrl.sv
hdl/huffman_code_builder_unit.sv
tb/hcb_checker.sv
tb/tb_huffman_code_builder_unit.sv
